FILE: sv/dtp_pkg.sv
package dtp_pkg;

    localparam int MAX_ENTRY_LEN_DEF = 16;
    localparam int DICT_ENTRIES_DEF  = 59;
    localparam int TABLE_ROWS        = 59;
    localparam int PAT_BYTES         = 16;
    localparam int EXT_FIRST         = 35;
    localparam int EXT_COUNT         = 7;

    localparam logic [7:0] TOKEN_BASE  = 8'h81;
    localparam logic [7:0] ESCAPE_BYTE = 8'h80;

    typedef enum logic [0:0] {
        REG_ESCAPE_HIGH = 1'b0,
        REG_EXTENDED    = 1'b1
    } cfg_reg_t;

    typedef logic [8*PAT_BYTES-1:0] pattern_t;

    // hex rows hold ASCII, first character in the highest used byte
    localparam pattern_t DICT_TEXT [TABLE_ROWS] = '{
        " *)", "*)", "*,",
        "int x", "int y", "int z",
        "int a", "int b", "int c",
        "register ", "unsigned ", "signed ",
        "volatile ", "void _(", "int _(",
        "short _(", "BOOL _(", "long _(",
        " *_(", "*_(", "const ",
        "void,(", "char,(", "int,(",
        "short,(", "long,(", "float,(",
        "void", "char", "int",
        "short", "long", "float",
        "typedef struct", "typedef ",
        "FIXED ", "HANDLE ", "BGS *",
        "SCREEN *", "POINT *", "FIXED *",
        "PLANE *p",
        "Gray", "_RR(", ",15",
        ",(", "),", "({",
        "})",
        128'h000000000000_5f726f6d5f_63616c6c28,
        128'h00_5f726f6d5f_63616c6c5f_6164647228,
        "FILE*",
        128'h5f5f41545452_5f4c49425f41_534d5f5f,
        128'h0000_5f5f41545452_5f4c49425f43_5f5f,
        128'h000000_5f5f41545452_5f54494f535f5f,
        "__ATTR_", " __",
        "__", " *"
    };

    localparam int DICT_LEN [TABLE_ROWS] = '{
        3, 2, 2, 5, 5, 5, 5, 5, 5, 9, 9, 7, 9, 7, 6, 8, 7, 7, 4, 3,
        6, 6, 6, 5, 7, 6, 7, 4, 4, 3, 5, 4, 5, 14, 8, 6, 7, 5, 8, 7,
        7, 8, 4, 4, 3, 2, 2, 2, 2, 10, 15, 5, 16, 14, 13, 7, 3, 2, 2
    };

endpackage

FILE: sv/dictionary_token_packer.sv
// Channel   Dir  Handshake                 Payload
// s_ (in)   in   s_tvalid / s_tready       s_tdata = text_byte, s_tlast = end_of_text
// m_ (out)  out  m_tvalid / m_tready       m_tdata = packed_byte, m_tlast = packed_last
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One input transaction per cycle while the window fills; once it holds
// MAX_ENTRY_LEN bytes a decision must shift it before the next load. An
// escaped literal needs an extra decision for the escape byte. End of text
// flushes one decision per cycle unless stalled by the output register, the only stall point.
// aresetn is synchronous, active low; window contents need no reset.
module dictionary_token_packer #(
    parameter int MAX_ENTRY_LEN = dtp_pkg::MAX_ENTRY_LEN_DEF,
    parameter int DICT_ENTRIES  = dtp_pkg::DICT_ENTRIES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] packed_byte
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data
);
    import dtp_pkg::*;

    localparam int FILL_W = $clog2(MAX_ENTRY_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRY_LEN);

    logic [7:0]        win_reg [MAX_ENTRY_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic              flush_reg;
    logic              esc_done_reg;
    logic              esc_en_reg;
    logic              ext_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic              decide_now;
    logic              out_load;
    logic              hit;
    logic [7:0]        hit_code;
    logic [FILL_W-1:0] hit_len;
    logic [FILL_W-1:0] skip_len;
    logic              need_esc;
    logic [FILL_W-1:0] fill_next;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign m_tlast   = out_last_reg;

    assign decide_now = (fill_reg == FILL_W'(MAX_ENTRY_LEN)) ||
                        (flush_reg && fill_reg != '0);
    assign out_load   = !out_valid_reg || m_tready;
    assign s_tready   = !decide_now && !flush_reg;

    always_comb begin
        logic ok;
        logic [7:0] pb;
        ok       = 1'b0;
        pb       = '0;
        hit      = 1'b0;
        hit_code = '0;
        hit_len  = '0;
        for (int r = TABLE_ROWS - 1; r >= 0; r--) begin
            if (r < DICT_ENTRIES && (ext_reg || r < EXT_FIRST || r >= EXT_FIRST + EXT_COUNT)) begin
                ok = FILL_W'(DICT_LEN[r]) <= fill_reg;
                for (int k = 0; k < PAT_BYTES; k++) begin
                    if (k < DICT_LEN[r]) begin
                        pb = DICT_TEXT[r][8*(DICT_LEN[r]-1-k) +: 8];
                        if (pb != win_reg[k]) ok = 1'b0;
                    end
                end
                if (ok) begin
                    hit      = 1'b1;
                    hit_len  = FILL_W'(DICT_LEN[r]);
                    hit_code = (ext_reg || r < EXT_FIRST) ? 8'(r) : 8'(r - EXT_COUNT);
                end
            end
        end
    end

    assign need_esc  = !hit && win_reg[0][7] && esc_en_reg && !esc_done_reg;
    assign skip_len  = hit ? hit_len : FILL_W'(1);
    assign fill_next = fill_reg - skip_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_en_reg <= 1'b1;
            ext_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ESCAPE_HIGH: esc_en_reg <= cfg_data;
                REG_EXTENDED:    ext_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            esc_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (decide_now && out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            if (decide_now && out_load) begin
                if (need_esc) begin
                    out_byte_reg <= ESCAPE_BYTE;
                    out_last_reg <= 1'b0;
                    esc_done_reg <= 1'b1;
                end else begin
                    out_byte_reg <= hit ? (TOKEN_BASE + hit_code) : win_reg[0];
                    out_last_reg <= flush_reg && fill_next == '0;
                    esc_done_reg <= 1'b0;
                    fill_reg     <= fill_next;
                    if (fill_next == '0) flush_reg <= 1'b0;
                    for (int i = 0; i < MAX_ENTRY_LEN; i++) begin
                        if (i + int'(skip_len) < MAX_ENTRY_LEN)
                            win_reg[i] <= win_reg[IDX_W'(i + int'(skip_len))];
                        else
                            win_reg[i] <= '0;
                    end
                end
            end else if (s_tvalid && s_tready) begin
                win_reg[fill_reg[IDX_W-1:0]] <= s_tdata;
                fill_reg  <= fill_reg + FILL_W'(1);
                flush_reg <= s_tlast;
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_ENTRY_LEN))
        else $error("window overfilled");
    a_no_accept_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> !s_tready)
        else $error("input taken during flush");
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (decide_now && out_load && !need_esc && flush_reg && fill_next == '0)
        |=> (fill_reg == '0 && m_tlast && m_tvalid))
        else $error("flush end mismatch");
    a_escape_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_done_reg |-> (decide_now && !hit))
        else $error("escape without literal");

endmodule
